[rtl/cs_pkg.sv]
// Package for the cosine similarity block: payload structs, accumulator types
// and shared widths. Used by every module of the block; depends on nothing.

package cs_pkg;

	localparam int SUM_W           = 48;
	localparam int ROOT_W          = 48;
	localparam int THR_W           = 48;
	localparam int CFG_DATA_W      = 64;
	localparam int CFG_ADDR_W      = 4;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic signed [15:0] COS_MAX = 16'sh7fff;
	localparam logic signed [15:0] COS_MIN = -16'sh8000;

	typedef struct packed {
		logic signed [15:0] x_value;
		logic signed [15:0] y_value;
		logic               last;
	} pair_t;

	typedef struct packed {
		logic signed [15:0] cosine;
		logic               degenerate;
	} result_t;

	// Finished sums of one vector pair, handed from the front to the back.
	typedef struct packed {
		logic        [SUM_W-1:0] sum_xx;
		logic        [SUM_W-1:0] sum_yy;
		logic signed [SUM_W-1:0] sum_xy;
	} sums_t;

endpackage

[rtl/cs_front.sv]
// Front end: takes one element pair per cycle while not stalled, squares and
// multiplies it and keeps the three saturating sums. Depends on cs_pkg.

module cs_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pair_valid,
	output logic          pair_stall,
	input  cs_pkg::pair_t pair,
	input  logic          queue_full,
	output logic          push,
	output cs_pkg::sums_t push_sums
);

	localparam int SW = cs_pkg::SUM_W;

	logic                 valid_s1;
	logic                 last_s1;
	logic        [30:0]   xx_s1;
	logic        [30:0]   yy_s1;
	logic signed [31:0]   xy_s1;

	logic        [SW-1:0] sum_xx_q;
	logic        [SW-1:0] sum_yy_q;
	logic signed [SW-1:0] sum_xy_q;

	logic signed [31:0]   xx_full;
	logic signed [31:0]   yy_full;
	logic signed [31:0]   xy_full;
	logic        [SW:0]   add_xx;
	logic        [SW:0]   add_yy;
	logic signed [SW:0]   add_xy;
	cs_pkg::sums_t        next_sums;
	logic                 advance;

	assign xx_full = 32'(pair.x_value) * 32'(pair.x_value);
	assign yy_full = 32'(pair.y_value) * 32'(pair.y_value);
	assign xy_full = 32'(pair.x_value) * 32'(pair.y_value);

	// A final pair waits in stage one until the queue has room for its sums.
	assign advance    = !(valid_s1 && last_s1 && queue_full);
	assign pair_stall = !advance;

	always_comb begin
		add_xx = {1'b0, sum_xx_q} + {{(SW - 30){1'b0}}, xx_s1};
		add_yy = {1'b0, sum_yy_q} + {{(SW - 30){1'b0}}, yy_s1};
		add_xy = {sum_xy_q[SW-1], sum_xy_q} + {{(SW - 31){xy_s1[31]}}, xy_s1};

		next_sums.sum_xx = add_xx[SW] ? {SW{1'b1}} : add_xx[SW-1:0];
		next_sums.sum_yy = add_yy[SW] ? {SW{1'b1}} : add_yy[SW-1:0];
		if (add_xy[SW] != add_xy[SW-1]) begin
			next_sums.sum_xy = add_xy[SW] ? {1'b1, {(SW - 1){1'b0}}}
			                              : {1'b0, {(SW - 1){1'b1}}};
		end else begin
			next_sums.sum_xy = add_xy[SW-1:0];
		end
	end

	assign push      = valid_s1 && last_s1 && !queue_full;
	assign push_sums = next_sums;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			sum_xx_q <= '0;
			sum_yy_q <= '0;
			sum_xy_q <= '0;
		end else if (advance) begin
			valid_s1 <= pair_valid;
			if (valid_s1) begin
				if (last_s1) begin
					sum_xx_q <= '0;
					sum_yy_q <= '0;
					sum_xy_q <= '0;
				end else begin
					sum_xx_q <= next_sums.sum_xx;
					sum_yy_q <= next_sums.sum_yy;
					sum_xy_q <= next_sums.sum_xy;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			last_s1 <= pair.last;
			xx_s1   <= xx_full[30:0];
			yy_s1   <= yy_full[30:0];
			xy_s1   <= xy_full;
		end
	end

endmodule

[rtl/cs_queue.sv]
// Short queue of finished vector sums between the front and the back end.
// Depends on cs_pkg for the entry type.

module cs_queue #(
	parameter int DEPTH = cs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cs_pkg::sums_t wdata,
	output logic          full,
	input  logic          pop,
	output logic          nonempty,
	output cs_pkg::sums_t rdata
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cs_pkg::sums_t      entry_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign nonempty = (count_q != '0);
	assign rdata    = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

[rtl/cs_back.sv]
// Back end: forms root = isqrt(sum_xx * sum_yy) one bit per cycle, divides the
// scaled dot product by it one bit per cycle and holds the result register.
// Depends on cs_pkg.

module cs_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      entry_valid,
	input  cs_pkg::sums_t             entry,
	output logic                      pop,
	input  logic [cs_pkg::THR_W-1:0]  threshold,
	output logic                      result_valid,
	input  logic                      result_stall,
	output cs_pkg::result_t           result
);

	localparam int SW         = cs_pkg::SUM_W;
	localparam int RW         = cs_pkg::ROOT_W;
	localparam int HW         = SW / 2;
	localparam int PW         = 2 * SW;
	localparam int NW         = SW + 15;
	localparam int SQRT_STEPS = RW;
	localparam int DIV_STEPS  = NW;
	localparam int MUL_STEPS  = 4;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_SQRT = 3'd2;
	localparam logic [2:0] ST_CMP  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]           state_q;
	logic [5:0]           cnt_q;
	logic [SW-1:0]        sxx_q;
	logic [SW-1:0]        syy_q;
	logic signed [SW-1:0] sxy_q;
	logic [PW-1:0]        pp_q;
	logic [PW-1:0]        prod_q;
	logic [RW+1:0]        rem_q;
	logic [RW-1:0]        root_q;
	logic [NW-1:0]        num_q;
	logic [RW-1:0]        drem_q;
	logic                 degen_q;
	logic                 neg_q;
	logic                 res_valid_q;
	cs_pkg::result_t      res_q;

	logic [HW-1:0]        a_part;
	logic [HW-1:0]        b_part;
	logic [SW-1:0]        pp;
	logic [PW-1:0]        pp_shifted;
	logic [RW+1:0]        rem_sh;
	logic [RW+1:0]        trial;
	logic                 sqrt_ge;
	logic [RW:0]          drem_sh;
	logic                 div_ge;
	logic [RW:0]          drem_sub;
	logic [SW-1:0]        mag;
	logic                 big;
	logic [16:0]          quo_up;
	logic signed [15:0]   cos_final;
	logic                 out_free;

	// Partial products of the 48 by 48 bit multiply, one quarter per cycle.
	always_comb begin
		a_part = cnt_q[1] ? sxx_q[SW-1:HW] : sxx_q[HW-1:0];
		b_part = cnt_q[0] ? syy_q[SW-1:HW] : syy_q[HW-1:0];
		pp     = {{HW{1'b0}}, a_part} * {{HW{1'b0}}, b_part};
		case (cnt_q[1:0])
			2'd0:    pp_shifted = {{SW{1'b0}}, pp};
			2'd3:    pp_shifted = {pp, {SW{1'b0}}};
			default: pp_shifted = {{HW{1'b0}}, pp, {HW{1'b0}}};
		endcase
	end

	// Digit recurrence of the square root: two radicand bits in, one root bit out.
	assign rem_sh   = {rem_q[RW-1:0], prod_q[PW-1:PW-2]};
	assign trial    = {root_q, 2'b01};
	assign sqrt_ge  = (rem_sh >= trial);

	// Restoring division of the magnitude shifted up by 15 bits.
	assign drem_sh  = {drem_q, num_q[NW-1]};
	assign div_ge   = (drem_sh >= {1'b0, root_q});
	assign drem_sub = drem_sh - {1'b0, root_q};

	assign mag = sxy_q[SW-1] ? SW'(-sxy_q) : SW'(sxy_q);

	always_comb begin
		big    = |num_q[NW-1:16];
		quo_up = {1'b0, num_q[15:0]} + {16'd0, (drem_q != '0)};
		if (degen_q) begin
			cos_final = '0;
		end else if (neg_q) begin
			// Floor of a negative ratio rounds the magnitude up.
			if (big || quo_up > 17'd32768) begin
				cos_final = cs_pkg::COS_MIN;
			end else begin
				cos_final = -$signed(quo_up[15:0]);
			end
		end else if (big || num_q[15]) begin
			cos_final = cs_pkg::COS_MAX;
		end else begin
			cos_final = $signed(num_q[15:0]);
		end
	end

	assign out_free     = !res_valid_q || !result_stall;
	assign pop          = (state_q == ST_IDLE) && entry_valid;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// The output state reloads the register itself when it is free.
			if (res_valid_q && !result_stall && state_q != ST_OUT) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (entry_valid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (cnt_q == 6'(MUL_STEPS)) begin
						cnt_q   <= '0;
						state_q <= ST_SQRT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SQRT: begin
					if (cnt_q == 6'(SQRT_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_CMP;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_CMP: begin
					state_q <= (root_q <= threshold) ? ST_OUT : ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == 6'(DIV_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_OUT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				sxx_q  <= entry.sum_xx;
				syy_q  <= entry.sum_yy;
				sxy_q  <= entry.sum_xy;
				prod_q <= '0;
			end
			ST_MUL: begin
				pp_q <= pp_shifted;
				if (cnt_q != '0) begin
					prod_q <= prod_q + pp_q;
				end
				rem_q  <= '0;
				root_q <= '0;
			end
			ST_SQRT: begin
				prod_q <= {prod_q[PW-3:0], 2'b00};
				rem_q  <= sqrt_ge ? rem_sh - trial : rem_sh;
				root_q <= {root_q[RW-2:0], sqrt_ge};
			end
			ST_CMP: begin
				degen_q <= (root_q <= threshold);
				neg_q   <= sxy_q[SW-1];
				num_q   <= {mag, 15'd0};
				drem_q  <= '0;
			end
			ST_DIV: begin
				// Quotient bits shift in where numerator bits shift out.
				num_q  <= {num_q[NW-2:0], div_ge};
				drem_q <= div_ge ? drem_sub[RW-1:0] : drem_sh[RW-1:0];
			end
			ST_OUT: begin
				if (out_free) begin
					res_q.cosine     <= cos_final;
					res_q.degenerate <= degen_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[rtl/cosine_similarity.sv]
// Top level of the cosine similarity block: configuration register, front
// end, sums queue and back end. Depends on cs_pkg, cs_front, cs_queue, cs_back.
//
// Element pairs are taken one per cycle with no gaps, also across vector
// boundaries, unless the input is stalled; each final pair hands its three
// sums to a short queue. The back end then loads the sums, does the 48 by 48
// bit multiply in quarters, the bit-serial square root, one compare, the
// bit-serial divide and a fill of the output register, and skips the divide
// when the result is degenerate. Short vectors only stall the input once
// the queue of QUEUE_DEPTH entries is full. A result is held in the output
// register until it is taken, while the next vector is already being
// accumulated.
// The threshold sits at byte address 0 of the configuration port.

module cosine_similarity #(
	parameter int QUEUE_DEPTH = cs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cs_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [cs_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [cs_pkg::CFG_DATA_W-1:0] prdata,
	output logic                          pready,
	input  logic                          pair_valid,
	output logic                          pair_stall,
	input  cs_pkg::pair_t                 pair,
	output logic                          result_valid,
	input  logic                          result_stall,
	output cs_pkg::result_t               result
);

	localparam int TW = cs_pkg::THR_W;
	localparam int DW = cs_pkg::CFG_DATA_W;
	localparam int AW = cs_pkg::CFG_ADDR_W;

	logic [TW-1:0]  thr_q;
	logic           thr_sel;
	logic           queue_full;
	logic           push;
	cs_pkg::sums_t  push_sums;
	logic           pop;
	logic           entry_valid;
	cs_pkg::sums_t  entry;

	// Only the first eight-byte word holds a register.
	assign thr_sel = !paddr[AW-1];
	assign pready  = 1'b1;
	assign prdata  = thr_sel ? {{(DW - TW){1'b0}}, thr_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (psel && penable && pwrite && thr_sel) begin
			thr_q <= pwdata[TW-1:0];
		end
	end

	cs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pair_valid (pair_valid),
		.pair_stall (pair_stall),
		.pair       (pair),
		.queue_full (queue_full),
		.push       (push),
		.push_sums  (push_sums)
	);

	cs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    (push_sums),
		.full     (queue_full),
		.pop      (pop),
		.nonempty (entry_valid),
		.rdata    (entry)
	);

	cs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.entry_valid  (entry_valid),
		.entry        (entry),
		.pop          (pop),
		.threshold    (thr_q),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

[rtl/cs_checker.sv]
// Port-level checks for the cosine similarity block, bound to the top level.
// Depends on cs_pkg and on the ports of cosine_similarity.

module cs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          pair_valid,
	input logic                          pair_stall,
	input cs_pkg::pair_t                 pair,
	input logic                          result_valid,
	input logic                          result_stall,
	input cs_pkg::result_t               result
);

	// Vectors whose final pair has been transferred but whose result has not.
	logic [7:0] pending_q;
	logic       last_in;
	logic       res_out;

	assign last_in = pair_valid && !pair_stall && pair.last;
	assign res_out = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (last_in && !res_out) begin
			pending_q <= pending_q + 1'b1;
		end else if (res_out && !last_in) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
	else $error("result changed while stalled");

	a_no_invented_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pending_q != '0)
	else $error("result without a final pair");

	a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pair_stall |-> pending_q != '0)
	else $error("input stalled with no vector in flight");

	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.degenerate |-> result.cosine == '0)
	else $error("degenerate result with non-zero cosine");

endmodule

bind cosine_similarity cs_checker u_cs_checker (.*);

[sim/tb_cosine_similarity.sv]
// Self-checking testbench for cosine_similarity: streams vector pairs, predicts
// each cosine result in fixed point and compares every result transfer.
// Depends on cs_pkg and the cosine_similarity RTL.
`timescale 1ns / 100ps

module tb_cosine_similarity;

	localparam int REG_NORM_THRESHOLD = 0;
	localparam logic [cs_pkg::CFG_ADDR_W-1:0] THR_ADDR =
		cs_pkg::CFG_ADDR_W'(8 * REG_NORM_THRESHOLD);
	localparam logic [cs_pkg::THR_W-1:0] THR_MAX = '1;
	localparam longint SUM_UMAX = 64'h0000_FFFF_FFFF_FFFF;
	localparam longint SUM_SMAX = 64'h0000_7FFF_FFFF_FFFF;
	localparam longint SUM_SMIN = -64'sh0000_8000_0000_0000;
	localparam int SETTLE_CYCLES = 300;

	typedef enum int {
		FILL_RANDOM,
		FILL_ALIKE,
		FILL_OPPOSED,
		FILL_SMALL,
		FILL_EDGE
	} fill_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [cs_pkg::CFG_ADDR_W-1:0] paddr = '0;
	logic [cs_pkg::CFG_DATA_W-1:0] pwdata = '0;
	logic [cs_pkg::CFG_DATA_W-1:0] prdata;
	logic                          pready;
	logic                          pair_valid = 1'b0;
	logic                          pair_stall;
	cs_pkg::pair_t                 pair = '0;
	logic                          result_valid;
	logic                          result_stall = 1'b0;
	cs_pkg::result_t               result;

	cs_pkg::pair_t   pair_q[$];
	cs_pkg::result_t cosine_q[$];

	// Predictor state: the three running sums and the threshold.
	longint                     acc_xx = 0;
	longint                     acc_yy = 0;
	longint                     acc_xy = 0;
	logic [cs_pkg::THR_W-1:0]   norm_thr = '0;

	int              mismatches = 0;
	bit              gaps_on = 1'b1;
	bit              pair_fire = 1'b0;
	bit              res_fire = 1'b0;
	int              send_gap = 0;
	int              res_wait = 0;
	logic            send_next;
	cs_pkg::result_t want;
	bit              has_result;

	cosine_similarity u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.pair_valid   (pair_valid),
		.pair_stall   (pair_stall),
		.pair         (pair),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #1 clk = ~clk;

	// Adds one pair into the sums; on a final pair works out the result and
	// clears the sums.
	function automatic bit take_pair(input cs_pkg::pair_t p, output cs_pkg::result_t r);
		longint      xv, yv;
		logic [95:0] prod, cand;
		logic [47:0] root;
		logic [63:0] mag, num, q, nq;
		bit          neg;
		xv = p.x_value;
		yv = p.y_value;
		r = '0;
		acc_xx = acc_xx + xv * xv;
		if (acc_xx > SUM_UMAX) acc_xx = SUM_UMAX;
		acc_yy = acc_yy + yv * yv;
		if (acc_yy > SUM_UMAX) acc_yy = SUM_UMAX;
		acc_xy = acc_xy + xv * yv;
		if (acc_xy > SUM_SMAX) acc_xy = SUM_SMAX;
		if (acc_xy < SUM_SMIN) acc_xy = SUM_SMIN;
		if (!p.last) return 1'b0;

		prod = 96'(acc_xx) * 96'(acc_yy);
		root = '0;
		for (int b = 47; b >= 0; b--) begin
			cand = 96'(root | (48'd1 << b));
			if (cand * cand <= prod) root = cand[47:0];
		end

		if (root <= norm_thr) begin
			r.cosine = '0;
			r.degenerate = 1'b1;
		end else begin
			neg = acc_xy < 0;
			mag = neg ? 64'(-acc_xy) : 64'(acc_xy);
			num = mag << 15;
			q = num / 64'(root);
			if (neg) begin
				// Flooring a negative quotient rounds its magnitude up.
				if (q * 64'(root) != num) q++;
				nq = -q;
				r.cosine = (q > 64'd32768) ? cs_pkg::COS_MIN : nq[15:0];
			end else begin
				r.cosine = (q > 64'd32767) ? cs_pkg::COS_MAX : q[15:0];
			end
			r.degenerate = 1'b0;
		end
		acc_xx = 0;
		acc_yy = 0;
		acc_xy = 0;
		return 1'b1;
	endfunction

	function automatic logic signed [15:0] edge_value();
		case ($urandom_range(0, 4))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return 16'sd0;
			3: return -16'sd1;
			default: return 16'sd1;
		endcase
	endfunction

	function automatic cs_pkg::pair_t make_pair(input fill_t f, input bit fin);
		cs_pkg::pair_t p;
		p.last = fin;
		case (f)
			FILL_ALIKE: begin
				p.x_value = 16'($urandom);
				p.y_value = p.x_value ^ 16'($urandom_range(0, 15));
			end
			FILL_OPPOSED: begin
				p.x_value = 16'($urandom);
				p.y_value = ~p.x_value ^ 16'($urandom_range(0, 15));
			end
			FILL_SMALL: begin
				p.x_value = 16'(int'($urandom_range(0, 6)) - 3);
				p.y_value = 16'(int'($urandom_range(0, 6)) - 3);
			end
			FILL_EDGE: begin
				p.x_value = edge_value();
				p.y_value = edge_value();
			end
			default: begin
				p.x_value = 16'($urandom);
				p.y_value = 16'($urandom);
			end
		endcase
		return p;
	endfunction

	task automatic push_pair(input int xv, input int yv, input bit fin);
		cs_pkg::pair_t p;
		p.x_value = 16'(xv);
		p.y_value = 16'(yv);
		p.last = fin;
		pair_q.push_back(p);
	endtask

	// Queues whole vectors, mostly short ones, until n_items pairs are added.
	task automatic queue_vectors(input int n_items, input int longest);
		int    added, len, pick;
		fill_t f;
		added = 0;
		while (added < n_items) begin
			pick = $urandom_range(0, 19);
			if (pick < 14) len = $urandom_range(1, 4);
			else if (pick < 19) len = $urandom_range(5, 32);
			else len = $urandom_range(33, longest);
			f = fill_t'($urandom_range(0, 4));
			for (int i = 0; i < len; i++) pair_q.push_back(make_pair(f, i == len - 1));
			added += len;
		end
	endtask

	task automatic wait_quiet();
		while (pair_q.size() != 0 || pair_valid || cosine_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [cs_pkg::THR_W-1:0] v);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = THR_ADDR;
		pwdata = cs_pkg::CFG_DATA_W'(v);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		norm_thr = v;
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[cs_pkg::THR_W-1:0] !== v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("threshold read back: expected %0d, got %0d",
					v, prdata[cs_pkg::THR_W-1:0]);
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// Sender: one pair at a time, with a random gap drawn for each transfer.
	always @(negedge clk) begin
		send_next = pair_valid;
		if (pair_valid && pair_fire) send_next = 1'b0;
		if (!send_next && arst_n) begin
			if (send_gap > 0) begin
				send_gap--;
			end else if (pair_q.size() != 0) begin
				pair <= pair_q.pop_front();
				send_next = 1'b1;
				send_gap = gaps_on ? $urandom_range(0, 4) : 0;
			end
		end
		pair_valid <= send_next;
	end

	// Receiver: stalls for a random number of cycles after each result transfer.
	always @(negedge clk) begin
		if (res_fire) res_wait = gaps_on ? $urandom_range(0, 4) : 0;
		if (res_wait > 0) begin
			res_wait--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			pair_fire = pair_valid && !pair_stall;
			if (pair_fire) begin
				has_result = take_pair(pair, want);
				if (has_result) cosine_q.push_back(want);
			end
			res_fire = result_valid && !result_stall;
			if (res_fire) begin
				if (cosine_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: cosine %0d degenerate %0b",
							result.cosine, result.degenerate);
				end else begin
					want = cosine_q.pop_front();
					if (result.cosine !== want.cosine ||
						result.degenerate !== want.degenerate) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result: cosine expected %0d got %0d, %s %0b got %0b",
								want.cosine, result.cosine, "degenerate expected",
								want.degenerate, result.degenerate);
					end
				end
			end
		end
	end

	initial begin
		logic [cs_pkg::THR_W-1:0] thr;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Degenerate, saturating, orthogonal and bit-pattern vectors.
		write_threshold('0);
		push_pair(0, 0, 1);
		push_pair(-32768, -32768, 1);
		push_pair(-32768, 32767, 1);
		push_pair(32767, -32768, 0);
		push_pair(-1, 1, 1);
		push_pair(32767, 32767, 0);
		push_pair(32767, 32767, 1);
		push_pair(1, 0, 1);
		push_pair(16'h5555, 16'hAAAA, 0);
		push_pair(16'hAAAA, 16'h5555, 1);
		push_pair(-1, -1, 1);
		push_pair(1, -1, 1);
		push_pair(100, 0, 0);
		push_pair(0, 100, 1);
		push_pair(3, -7, 0);
		push_pair(-5, 2, 0);
		push_pair(9, 9, 1);
		wait_quiet();

		// Roots just at and just above the threshold.
		write_threshold(48'd1);
		push_pair(1, 1, 1);
		push_pair(2, 2, 1);
		push_pair(-1, 1, 1);
		push_pair(1, 2, 1);
		wait_quiet();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: thr = 48'($urandom_range(1, 1000)) * 48'd1_000_000;
				1: thr = 48'($urandom_range(0, 4095));
				2: thr = '0;
				3: thr = {16'($urandom), 32'($urandom)} >> $urandom_range(0, 40);
				4: thr = THR_MAX;
				default: thr = 48'($urandom_range(1, 100)) * 48'd100_000_000;
			endcase
			write_threshold(thr);
			gaps_on = (ph != 1);
			if (ph == 2) begin
				// The sender holds off here until every result has come back.
				queue_vectors(150, 200);
				wait_quiet();
				queue_vectors(150, 200);
			end else begin
				queue_vectors(300, 300);
			end
			wait_quiet();
		end

		if (mismatches == 0 && cosine_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#6_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
